@@ rtl/mets_pkg.sv @@
// mets_pkg: shared types and constants of the mandelbrot escape-time pixel block
`default_nettype none

package mets_pkg;

    localparam int unsigned MULT_W      = 31;
    localparam int unsigned PROD_W      = 2 * MULT_W;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned DIVIDEND_W  = 32;
    localparam int unsigned COLOR_W     = 8;
    localparam int unsigned COLOR_SCALE = 65025;
    localparam int unsigned ALPHA_FULL  = 255;
    localparam int unsigned GREEN_ODD   = 64;

    localparam logic [12:0]        WIDTH_RST    = 13'd512;
    localparam logic [12:0]        HEIGHT_RST   = 13'd512;
    localparam logic signed [31:0] CENTER_X_RST = -32'sd22229811;
    localparam logic signed [31:0] CENTER_Y_RST = 32'sd0;
    localparam logic [30:0]        STEP_RST     = 31'd32768;
    localparam logic [30:0]        LIMIT_RST    = 31'd1677721600;
    localparam logic [15:0]        MAX_ITER_RST = 16'd256;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_CENTER_X        = 3'd2,
        REG_CENTER_Y        = 3'd3,
        REG_STEP_X          = 3'd4,
        REG_STEP_Y          = 3'd5,
        REG_ESCAPE_LIMIT_SQ = 3'd6,
        REG_MAX_ITERATIONS  = 3'd7
    } cfg_index_t;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_MAP_X     = 13'b0000000000010,
        ST_MAP_Y     = 13'b0000000000100,
        ST_MAP_C     = 13'b0000000001000,
        ST_SQ_X      = 13'b0000000010000,
        ST_SQ_Y      = 13'b0000000100000,
        ST_CROSS     = 13'b0000001000000,
        ST_UPDATE    = 13'b0000010000000,
        ST_COL_MUL   = 13'b0000100000000,
        ST_COL_START = 13'b0001000000000,
        ST_COL_WAIT  = 13'b0010000000000,
        ST_FINISH    = 13'b0100000000000,
        ST_SPARE     = 13'b1000000000000
    } seq_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [COUNT_W-1:0]    divisor;
    } color_req_t;

endpackage

`default_nettype wire

@@ rtl/mets_mult.sv @@
// mets_mult: shared unsigned multiplier with registered product
`default_nettype none

module mets_mult
    import mets_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [MULT_W-1:0] op_a,
    input  wire logic [MULT_W-1:0] op_b,
    output logic      [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/mets_color.sv @@
// mets_color: bit-serial divide and integer square root for the pixel color
`default_nettype none

module mets_color
    import mets_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire color_req_t         req,
    output logic                    done,
    output logic      [COLOR_W-1:0] color
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_DIV  = 3'b010,
        C_SQRT = 3'b100
    } color_state_t;

    color_state_t        state_reg, state_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [COUNT_W-1:0]  rem_reg;
    logic [COUNT_W-1:0]  quo_reg;
    logic [COUNT_W-1:0]  den_reg;
    logic [COLOR_W-1:0]  root_reg;

    logic [COUNT_W:0]    trial;
    logic                trial_ok;
    logic [COLOR_W-1:0]  cand;
    logic [COUNT_W-1:0]  cand_sq;

    // one quotient bit per step
    assign trial    = {rem_reg, quo_reg[COUNT_W-1]};
    assign trial_ok = trial >= {1'b0, den_reg};

    // one root bit per step
    assign cand    = root_reg | (COLOR_W'(1) << cnt_reg[2:0]);
    assign cand_sq = COUNT_W'(cand) * COUNT_W'(cand);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    state_next = C_DIV;
                    cnt_next   = 4'd15;
                end
            end
            C_DIV:
            begin
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = C_SQRT;
                    cnt_next   = 4'd7;
                end
            end
            C_SQRT:
            begin
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = C_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= 4'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    rem_reg  <= req.dividend[DIVIDEND_W-1:COUNT_W];
                    quo_reg  <= req.dividend[COUNT_W-1:0];
                    den_reg  <= req.divisor;
                    root_reg <= '0;
                end
            end
            C_DIV:
            begin
                rem_reg <= trial_ok ? COUNT_W'(trial - {1'b0, den_reg}) : trial[COUNT_W-1:0];
                quo_reg <= {quo_reg[COUNT_W-2:0], trial_ok};
            end
            C_SQRT:
            begin
                if (cand_sq <= quo_reg)
                begin
                    root_reg <= cand;
                end
            end
            default:
            begin
                root_reg <= root_reg;
            end
        endcase
    end

    assign done  = done_reg;
    assign color = root_reg;

endmodule

`default_nettype wire

@@ rtl/mandelbrot_escape_time_pixel.sv @@
// mandelbrot_escape_time_pixel: escape-time iteration and coloring of one pixel
//
//   port group   dir   beat carries
//   in_*         in    pixel_x, pixel_y
//   out_*        out   iteration_count, escaped, red, green, blue, alpha
//   cfg_*        in    cfg_index, cfg_data (always ready)
//
// per pixel: MAP_X, MAP_Y and MAP_C map it; each iteration uses the one shared
// multiplier in SQ_X, SQ_Y, CROSS and UPDATE, with the escape test in SQ_X and CROSS;
// escaped pixels are colored in COL_MUL, COL_START, COL_WAIT; FINISH hands over, then idle
// reset clears the sequencer and the output beat and loads the default view
// in_ready is high only in idle; a finished result may wait for out_ready
// while the next pixel is taken, and a pixel done before that holds in finish
`default_nettype none

module mandelbrot_escape_time_pixel
    import mets_pkg::*;
#(
    parameter int FRAC_BITS  = 24,
    parameter int COORD_BITS = 32,
    parameter int DIM_BITS   = 12
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [DIM_BITS-1:0] pixel_x,
    input  wire logic [DIM_BITS-1:0] pixel_y,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [COUNT_W-1:0]       iteration_count,
    output logic                     escaped,
    output logic [COLOR_W-1:0]       red,
    output logic [COLOR_W-1:0]       green,
    output logic [COLOR_W-1:0]       blue,
    output logic [COLOR_W-1:0]       alpha,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);

    localparam int TW = (DIM_BITS + 2 > 14) ? DIM_BITS + 2 : 14;
    localparam logic signed [63:0] CoordMax = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] CoordMin = -CoordMax - 64'sd1;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [63:0] v);
        if (v > CoordMax)
            return CoordMax[COORD_BITS-1:0];
        else if (v < CoordMin)
            return CoordMin[COORD_BITS-1:0];
        else
            return v[COORD_BITS-1:0];
    endfunction

    // configuration
    logic [12:0]        image_width_reg, image_height_reg;
    logic signed [31:0] center_x_reg, center_y_reg;
    logic [30:0]        step_x_reg, step_y_reg, limit_reg;
    logic [15:0]        max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
            center_x_reg     <= CENTER_X_RST;
            center_y_reg     <= CENTER_Y_RST;
            step_x_reg       <= STEP_RST;
            step_y_reg       <= STEP_RST;
            limit_reg        <= LIMIT_RST;
            max_iter_reg     <= MAX_ITER_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:     image_width_reg  <= cfg_data[12:0];
                REG_IMAGE_HEIGHT:    image_height_reg <= cfg_data[12:0];
                REG_CENTER_X:        center_x_reg     <= cfg_data;
                REG_CENTER_Y:        center_y_reg     <= cfg_data;
                REG_STEP_X:          step_x_reg       <= cfg_data[30:0];
                REG_STEP_Y:          step_y_reg       <= cfg_data[30:0];
                REG_ESCAPE_LIMIT_SQ: limit_reg        <= cfg_data[30:0];
                REG_MAX_ITERATIONS:  max_iter_reg     <= cfg_data[15:0];
                default:             max_iter_reg     <= max_iter_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // sequencer and datapath registers
    seq_state_t                   state_reg, state_next;
    logic [DIM_BITS-1:0]          px_reg, py_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg, cx_reg, cy_reg;
    logic [PROD_W-1:0]            x2_reg;
    logic signed [63:0]           diff_reg;
    logic [COUNT_W-1:0]           iter_reg;
    logic                         esc_reg;

    logic                         out_valid_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic                         escaped_reg;
    logic [COLOR_W-1:0]           red_reg, green_reg, blue_reg, alpha_reg;

    // shared multiplier
    logic [MULT_W-1:0] op_a, op_b;
    logic [PROD_W-1:0] prod;

    mets_mult u_mult (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // color unit
    color_req_t         color_req;
    logic               color_done;
    logic [COLOR_W-1:0] color;

    mets_color u_color (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (color_req),
        .done  (color_done),
        .color (color)
    );

    assign color_req.start    = state_reg == ST_COL_START;
    assign color_req.dividend = prod[DIVIDEND_W-1:0];
    assign color_req.divisor  = max_iter_reg;

    // pixel to plane mapping
    logic signed [TW-1:0] tx, ty;
    logic [TW-1:0]        tx_mag, ty_mag;
    logic                 map_neg;
    logic signed [63:0]   map_prod, map_center;
    logic signed [COORD_BITS-1:0] map_coord;

    assign tx     = $signed(TW'({px_reg, 1'b0})) - $signed(TW'(image_width_reg));
    assign ty     = $signed(TW'({py_reg, 1'b0})) - $signed(TW'(image_height_reg));
    assign tx_mag = tx[TW-1] ? TW'(-tx) : TW'(tx);
    assign ty_mag = ty[TW-1] ? TW'(-ty) : TW'(ty);

    assign map_neg    = (state_reg == ST_MAP_Y) ? tx[TW-1] : ty[TW-1];
    assign map_prod   = map_neg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
    assign map_center = (state_reg == ST_MAP_Y) ?
                        $signed({{32{center_x_reg[31]}}, center_x_reg}) :
                        $signed({{32{center_y_reg[31]}}, center_y_reg});
    assign map_coord  = sat_coord((map_prod >>> 1) + map_center);

    // iteration datapath
    logic [COORD_BITS-1:0] mx_full, my_full;
    logic [63:0]           mx64, my64;
    logic                  huge;
    logic [63:0]           mag_sum, limit64;
    logic                  esc_hit;
    logic signed [63:0]    diff;
    logic                  cross_neg;
    logic signed [63:0]    xy2;
    logic signed [63:0]    cx_ext, cy_ext;
    logic signed [COORD_BITS-1:0] x_new, y_new;
    logic [COUNT_W:0]      iter_inc;
    logic                  iter_last;

    assign mx_full = x_reg[COORD_BITS-1] ? COORD_BITS'(-x_reg) : COORD_BITS'(x_reg);
    assign my_full = y_reg[COORD_BITS-1] ? COORD_BITS'(-y_reg) : COORD_BITS'(y_reg);
    assign mx64    = 64'(mx_full);
    assign my64    = 64'(my_full);
    assign huge    = (|mx64[63:31]) | (|my64[63:31]);

    assign mag_sum = 64'(x2_reg) + 64'(prod);
    assign limit64 = 64'(limit_reg) << FRAC_BITS;
    assign esc_hit = mag_sum >= limit64;
    assign diff    = $signed(64'(x2_reg)) - $signed(64'(prod));

    assign cross_neg = x_reg[COORD_BITS-1] ^ y_reg[COORD_BITS-1];
    assign xy2       = cross_neg ? -$signed({1'b0, prod, 1'b0}) : $signed({1'b0, prod, 1'b0});
    assign cx_ext    = $signed({{(64 - COORD_BITS){cx_reg[COORD_BITS-1]}}, cx_reg});
    assign cy_ext    = $signed({{(64 - COORD_BITS){cy_reg[COORD_BITS-1]}}, cy_reg});
    assign x_new     = sat_coord((diff_reg >>> FRAC_BITS) + cx_ext);
    assign y_new     = sat_coord((xy2 >>> FRAC_BITS) + cy_ext);

    assign iter_inc  = (COUNT_W + 1)'(iter_reg) + (COUNT_W + 1)'(1);
    assign iter_last = iter_inc >= (COUNT_W + 1)'(max_iter_reg);

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_MAP_X:
            begin
                op_a = MULT_W'(tx_mag);
                op_b = step_x_reg;
            end
            ST_MAP_Y:
            begin
                op_a = MULT_W'(ty_mag);
                op_b = step_y_reg;
            end
            ST_SQ_X:
            begin
                op_a = mx64[MULT_W-1:0];
                op_b = mx64[MULT_W-1:0];
            end
            ST_SQ_Y:
            begin
                op_a = my64[MULT_W-1:0];
                op_b = my64[MULT_W-1:0];
            end
            ST_CROSS:
            begin
                op_a = mx64[MULT_W-1:0];
                op_b = my64[MULT_W-1:0];
            end
            ST_COL_MUL:
            begin
                op_a = MULT_W'(iter_reg);
                op_b = MULT_W'(COLOR_SCALE);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_MAP_X;
            ST_MAP_X:     state_next = ST_MAP_Y;
            ST_MAP_Y:     state_next = ST_MAP_C;
            ST_MAP_C:     state_next = (max_iter_reg == '0) ? ST_FINISH : ST_SQ_X;
            ST_SQ_X:      state_next = huge ? ST_COL_MUL : ST_SQ_Y;
            ST_SQ_Y:      state_next = ST_CROSS;
            ST_CROSS:     state_next = esc_hit ? ST_COL_MUL : ST_UPDATE;
            ST_UPDATE:    state_next = iter_last ? ST_FINISH : ST_SQ_X;
            ST_COL_MUL:   state_next = ST_COL_START;
            ST_COL_START: state_next = ST_COL_WAIT;
            ST_COL_WAIT:  if (color_done) state_next = ST_FINISH;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    px_reg   <= pixel_x;
                    py_reg   <= pixel_y;
                    iter_reg <= '0;
                    esc_reg  <= 1'b0;
                end
            end
            ST_MAP_Y:
            begin
                cx_reg <= map_coord;
                x_reg  <= map_coord;
            end
            ST_MAP_C:
            begin
                cy_reg <= map_coord;
                y_reg  <= map_coord;
            end
            ST_SQ_X:
            begin
                if (huge)
                begin
                    esc_reg <= 1'b1;
                end
            end
            ST_SQ_Y:
            begin
                x2_reg <= prod;
            end
            ST_CROSS:
            begin
                diff_reg <= diff;
                if (esc_hit)
                begin
                    esc_reg <= 1'b1;
                end
            end
            ST_UPDATE:
            begin
                x_reg    <= x_new;
                y_reg    <= y_new;
                iter_reg <= iter_inc[COUNT_W-1:0];
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    count_reg   <= iter_reg;
                    escaped_reg <= esc_reg;
                    red_reg     <= esc_reg ? COLOR_W'(ALPHA_FULL) - color : '0;
                    green_reg   <= (esc_reg && color[0]) ? COLOR_W'(GREEN_ODD) : '0;
                    blue_reg    <= esc_reg ? color : '0;
                    alpha_reg   <= esc_reg ? COLOR_W'(ALPHA_FULL) : '0;
                end
            end
            default:
            begin
                iter_reg <= iter_reg;
            end
        endcase
    end

    assign in_ready        = state_reg == ST_IDLE;
    assign out_valid       = out_valid_reg;
    assign iteration_count = count_reg;
    assign escaped         = escaped_reg;
    assign red             = red_reg;
    assign green           = green_reg;
    assign blue            = blue_reg;
    assign alpha           = alpha_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("pixel taken while a pixel is in flight");

    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !escaped |-> red == '0 && green == '0 && blue == '0 && alpha == '0)
        else $error("inside pixel carries color");

    a_color_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        color_done |-> state_reg == ST_COL_WAIT)
        else $error("color unit finished outside its wait state");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(iteration_count))
        else $error("result beat dropped or overwritten");
`endif

endmodule

`default_nettype wire

@@ sim/tb_mandelbrot_escape_time_pixel.sv @@
// testbench of the mandelbrot escape-time pixel block with a predicting scoreboard
module tb_mandelbrot_escape_time_pixel
    import mets_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    localparam int     FRAC            = 24;
    localparam longint COORD_MAX       = 64'sd2147483647;
    localparam longint COORD_MIN       = -64'sd2147483648;
    localparam u64_t   HUGE_MAG        = 64'h8000_0000;
    localparam int     RANDOM_ITEMS    = 1750;
    localparam int     CALM_ITEMS      = 150;
    localparam int     PRESSURE_AT     = 400;
    localparam int     PRESSURE_CYCLES = 3000;
    localparam int     WATCHDOG_LIMIT  = 20000;
    localparam int     PRINT_LIMIT     = 40;

    typedef struct packed {
        logic [12:0]        width;
        logic [12:0]        height;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        step_x;
        logic [30:0]        step_y;
        logic [30:0]        limit;
        logic [15:0]        max_iter;
    } view_t;

    typedef struct packed {
        logic [15:0] count;
        logic        escaped;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } pixel_t;

    class pixel_scoreboard;
        view_t  view;
        pixel_t expected_pixels[$];
        int     errors;
        int     checked;

        function new();
            view.width    = WIDTH_RST;
            view.height   = HEIGHT_RST;
            view.center_x = CENTER_X_RST;
            view.center_y = CENTER_Y_RST;
            view.step_x   = STEP_RST;
            view.step_y   = STEP_RST;
            view.limit    = LIMIT_RST;
            view.max_iter = MAX_ITER_RST;
            errors        = 0;
            checked       = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [31:0] data);
            case (idx)
                REG_IMAGE_WIDTH:     view.width    = data[12:0];
                REG_IMAGE_HEIGHT:    view.height   = data[12:0];
                REG_CENTER_X:        view.center_x = data;
                REG_CENTER_Y:        view.center_y = data;
                REG_STEP_X:          view.step_x   = data[30:0];
                REG_STEP_Y:          view.step_y   = data[30:0];
                REG_ESCAPE_LIMIT_SQ: view.limit    = data[30:0];
                REG_MAX_ITERATIONS:  view.max_iter = data[15:0];
                default: ;
            endcase
        endfunction

        function longint clamp_coord(longint v);
            if (v > COORD_MAX)
                return COORD_MAX;
            if (v < COORD_MIN)
                return COORD_MIN;
            return v;
        endfunction

        function longint map_axis(logic [11:0] p, logic [12:0] dim, logic [30:0] stp,
                                  logic signed [31:0] ctr);
            longint t;
            t = 2 * longint'(p) - longint'(dim);
            return clamp_coord(((t * longint'(stp)) >>> 1) + longint'(ctr));
        endfunction

        function logic [7:0] color_of(logic [15:0] it, logic [15:0] cap);
            u64_t q;
            u64_t r;
            u64_t c;
            q = (u64_t'(it) * COLOR_SCALE) / u64_t'(cap);
            r = 0;
            for (int b = 15; b >= 0; b--)
            begin
                c = r | (u64_t'(1) << b);
                if (c * c <= q)
                    r = c;
            end
            return r[7:0];
        endfunction

        function pixel_t escape_pixel(logic [11:0] px, logic [11:0] py);
            longint      cx;
            longint      cy;
            longint      x;
            longint      y;
            longint      xy;
            u64_t        mx;
            u64_t        my;
            u64_t        x2;
            u64_t        y2;
            u64_t        lim;
            int unsigned it;
            bit          esc;
            logic [7:0]  color;
            pixel_t      r;
            cx  = map_axis(px, view.width, view.step_x, view.center_x);
            cy  = map_axis(py, view.height, view.step_y, view.center_y);
            lim = u64_t'(view.limit) << FRAC;
            x   = cx;
            y   = cy;
            it  = 0;
            esc = 1'b0;
            while (it < view.max_iter && !esc)
            begin
                mx = u64_t'(x < 0 ? -x : x);
                my = u64_t'(y < 0 ? -y : y);
                if (mx >= HUGE_MAG || my >= HUGE_MAG)
                    esc = 1'b1;
                else
                begin
                    x2 = mx * mx;
                    y2 = my * my;
                    if (x2 + y2 >= lim)
                        esc = 1'b1;
                    else
                    begin
                        xy = longint'(mx * my);
                        if ((x < 0) != (y < 0))
                            xy = -xy;
                        x = clamp_coord(((longint'(x2) - longint'(y2)) >>> FRAC) + cx);
                        y = clamp_coord(((2 * xy) >>> FRAC) + cy);
                        it++;
                    end
                end
            end
            r.count   = it[15:0];
            r.escaped = esc;
            if (esc)
            begin
                color   = color_of(it[15:0], view.max_iter);
                r.red   = 8'(ALPHA_FULL) - color;
                r.green = color[0] ? 8'(GREEN_ODD) : 8'd0;
                r.blue  = color;
                r.alpha = 8'(ALPHA_FULL);
            end
            else
            begin
                r.red   = 8'd0;
                r.green = 8'd0;
                r.blue  = 8'd0;
                r.alpha = 8'd0;
            end
            return r;
        endfunction

        function void note_pixel(logic [11:0] px, logic [11:0] py);
            expected_pixels.push_back(escape_pixel(px, py));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                report("result beat with no pixel pending");
                return;
            end
            want = expected_pixels.pop_front();
            if (got.count !== want.count)
                report($sformatf("pixel %0d iteration_count got %0d expected %0d",
                                 checked, got.count, want.count));
            if (got.escaped !== want.escaped)
                report($sformatf("pixel %0d escaped got %0b expected %0b",
                                 checked, got.escaped, want.escaped));
            if (got.red !== want.red)
                report($sformatf("pixel %0d red got %0d expected %0d",
                                 checked, got.red, want.red));
            if (got.green !== want.green)
                report($sformatf("pixel %0d green got %0d expected %0d",
                                 checked, got.green, want.green));
            if (got.blue !== want.blue)
                report($sformatf("pixel %0d blue got %0d expected %0d",
                                 checked, got.blue, want.blue));
            if (got.alpha !== want.alpha)
                report($sformatf("pixel %0d alpha got %0d expected %0d",
                                 checked, got.alpha, want.alpha));
            checked++;
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [11:0] pixel_x   = '0;
    logic [11:0] pixel_y   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        in_ready;
    logic        out_valid;
    logic        cfg_ready;
    logic [15:0] iteration_count;
    logic        escaped;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;

    pixel_scoreboard sb = new();
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int results_seen = 0;

    mandelbrot_escape_time_pixel dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .iteration_count (iteration_count),
        .escaped         (escaped),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .alpha           (alpha),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_pixel(logic [11:0] px, logic [11:0] py);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= px;
        pixel_y  <= py;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        sb.note_pixel(px, py);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // unused upper data bits get random junk now and then
    task automatic apply_view(view_t v);
        logic [31:0] pad;
        pad = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
        write_reg(REG_IMAGE_WIDTH, {pad[31:13], v.width});
        write_reg(REG_IMAGE_HEIGHT, {pad[31:13], v.height});
        write_reg(REG_CENTER_X, v.center_x);
        write_reg(REG_CENTER_Y, v.center_y);
        write_reg(REG_STEP_X, {pad[31], v.step_x});
        write_reg(REG_STEP_Y, {pad[31], v.step_y});
        write_reg(REG_ESCAPE_LIMIT_SQ, {pad[31], v.limit});
        write_reg(REG_MAX_ITERATIONS, {pad[31:16], v.max_iter});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [11:0] pick_coord(logic [12:0] dim, bit wide);
        if (wide || dim == 13'd0)
            return 12'($urandom());
        return 12'($urandom_range((dim > 13'd4096) ? 4095 : int'(dim) - 1));
    endfunction

    function automatic logic [12:0] pick_dim();
        case ($urandom_range(11))
            0:       return 13'd0;
            1:       return 13'h1FFF;
            2:       return 13'd4096;
            3:       return 13'd1;
            4:       return 13'($urandom_range(4096, 1));
            default: return 13'($urandom_range(640, 16));
        endcase
    endfunction

    function automatic logic [30:0] pick_step(logic [12:0] dim, int unsigned span);
        case ($urandom_range(11))
            0:       return 31'd0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'($urandom());
            default: return 31'((u64_t'(span) << FRAC) / u64_t'(dim == 13'd0 ? 13'd64 : dim));
        endcase
    endfunction

    function automatic view_t random_view();
        view_t       v;
        int unsigned span;
        v.width  = pick_dim();
        v.height = pick_dim();
        span     = $urandom_range(4, 1);
        v.step_x = pick_step(v.width, span);
        v.step_y = pick_step(v.height, span);
        case ($urandom_range(9))
            0:       v.center_x = 32'h7FFF_FFFF;
            1:       v.center_x = 32'h8000_0000;
            2:       v.center_x = $urandom();
            default: v.center_x = 32'($urandom_range(41943040)) - 32'd33554432;
        endcase
        case ($urandom_range(9))
            0:       v.center_y = 32'h7FFF_FFFF;
            1:       v.center_y = 32'h8000_0000;
            2:       v.center_y = $urandom();
            default: v.center_y = 32'($urandom_range(33554432)) - 32'd16777216;
        endcase
        case ($urandom_range(7))
            0:       v.limit = 31'd0;
            1:       v.limit = 31'h7FFF_FFFF;
            2:       v.limit = 31'($urandom());
            3, 4:    v.limit = LIMIT_RST;
            default: v.limit = 31'd67108864;
        endcase
        case ($urandom_range(11))
            0:       v.max_iter = 16'd0;
            1:       v.max_iter = 16'd1;
            2:       v.max_iter = 16'($urandom_range(200, 64));
            default: v.max_iter = 16'($urandom_range(40, 2));
        endcase
        return v;
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 15;
            default: return 50;
        endcase
    endfunction

    // result side: random stalls plus one long hold-off to back up the block
    initial
    begin
        int     hold;
        pixel_t got;
        hold = 0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                got.count   = iteration_count;
                got.escaped = escaped;
                got.red     = red;
                got.green   = green;
                got.blue    = blue;
                got.alpha   = alpha;
                sb.check_pixel(got);
                results_seen++;
                if (results_seen == PRESSURE_AT)
                    hold = PRESSURE_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct)
            begin
                hold = $urandom_range(17, 1) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready) || (cfg_valid && cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        view_t v;
        int    sent;
        int    n;
        bit    wide;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default view straight out of reset
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'd256, 12'd256);
        send_pixel(12'd511, 12'd255);
        send_pixel(12'd100, 12'd300);
        wait_drain();

        // zero cap
        v = sb.view;
        v.max_iter = 16'd0;
        apply_view(v);
        send_pixel(12'd256, 12'd256);
        send_pixel(12'hFFF, 12'd7);
        wait_drain();

        // saturated mapping and huge magnitude
        v.width    = 13'd0;
        v.height   = 13'h1FFF;
        v.center_x = 32'h7FFF_FFFF;
        v.center_y = 32'h7FFF_FFFF;
        v.step_x   = 31'h7FFF_FFFF;
        v.step_y   = 31'h7FFF_FFFF;
        v.max_iter = 16'd16;
        apply_view(v);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd0, 12'hFFF);
        wait_drain();
        v.center_x = 32'h8000_0000;
        v.center_y = 32'h8000_0000;
        apply_view(v);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        wait_drain();

        // largest cap on a view where every point leaves fast
        v.width    = 13'd0;
        v.height   = 13'd0;
        v.center_x = 32'sd33554432;
        v.center_y = 32'sd0;
        v.step_x   = 31'd1048576;
        v.step_y   = 31'd1048576;
        v.limit    = LIMIT_RST;
        v.max_iter = 16'hFFFF;
        apply_view(v);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd2048, 12'd1);
        wait_drain();
        v.limit = 31'd0;
        apply_view(v);
        send_pixel(12'd1, 12'd2);
        wait_drain();
        v.limit    = 31'h7FFF_FFFF;
        v.max_iter = 16'd1;
        apply_view(v);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd3000, 12'd5);
        wait_drain();

        // zero step pins every pixel on the origin, inside the set
        v.width    = 13'h1FFF;
        v.height   = 13'h1FFF;
        v.center_x = 32'sd0;
        v.center_y = 32'sd0;
        v.step_x   = 31'd0;
        v.step_y   = 31'd0;
        v.limit    = 31'd67108864;
        v.max_iter = 16'd255;
        apply_view(v);
        send_pixel(12'd123, 12'd4000);
        send_pixel(12'hAAA, 12'h555);
        wait_drain();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            v = random_view();
            apply_view(v);
            in_idle_pct  = pick_idle();
            out_idle_pct = pick_idle();
            n = $urandom_range(80, 30);
            for (int i = 0; i < n; i++)
            begin
                wide = ($urandom_range(4) == 0);
                send_pixel(pick_coord(v.width, wide), pick_coord(v.height, wide));
                sent++;
            end
            wait_drain();
        end

        // closing stretch with no stalls on either side
        v = random_view();
        apply_view(v);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        for (int i = 0; i < CALM_ITEMS; i++)
        begin
            wide = ($urandom_range(4) == 0);
            send_pixel(pick_coord(v.width, wide), pick_coord(v.height, wide));
        end
        wait_drain();
        repeat (64) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
